>>> hw/rtl/mml_pkg.sv
// Shared types, token kind codes and character classes of the token lexer.
package mml_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned NUM_SLOTS         = 3;

  // Token kind codes
  localparam logic [4:0] K_INT    = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_PLUS   = 5'd2;
  localparam logic [4:0] K_MINUS  = 5'd3;
  localparam logic [4:0] K_SLASH  = 5'd4;
  localparam logic [4:0] K_STAR   = 5'd5;
  localparam logic [4:0] K_EQUAL  = 5'd6;
  localparam logic [4:0] K_LPAREN = 5'd7;
  localparam logic [4:0] K_RPAREN = 5'd8;
  localparam logic [4:0] K_SEMI   = 5'd9;
  localparam logic [4:0] K_COMMA  = 5'd10;
  localparam logic [4:0] K_COLON  = 5'd11;
  localparam logic [4:0] K_LBRACK = 5'd12;
  localparam logic [4:0] K_RBRACK = 5'd13;
  localparam logic [4:0] K_QUOTE  = 5'd14;
  localparam logic [4:0] K_AT     = 5'd15;
  localparam logic [4:0] K_HASH   = 5'd16;
  localparam logic [4:0] K_QMARK  = 5'd17;
  localparam logic [4:0] K_PIPE   = 5'd18;
  localparam logic [4:0] K_DOLLAR = 5'd19;
  localparam logic [4:0] K_CARET  = 5'd20;
  localparam logic [4:0] K_DCOLON = 5'd21;
  localparam logic [4:0] K_PIPEQ  = 5'd22;
  localparam logic [4:0] K_END    = 5'd23;
  localparam logic [4:0] K_ERROR  = 5'd24;
  localparam logic [4:0] K_SKIP   = 5'd30;
  localparam logic [4:0] K_NONE   = 5'd31;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } res_t;

  // Results caused by one input word, slot 0 first
  typedef struct packed {
    res_t [NUM_SLOTS-1:0] slot;
    logic [1:0]           cnt;
  } bundle_t;

  typedef struct packed {
    logic failed;
    logic pend_valid;
  } core_stat_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           (b == 8'h5F);
  endfunction

  // Kind that a byte opens; K_SKIP for blanks, K_ERROR when nothing matches
  function automatic logic [4:0] start_kind(input logic [7:0] b);
    logic [4:0] k;
    if (is_digit(b)) begin
      k = K_INT;
    end else if (is_alpha(b)) begin
      k = K_IDENT;
    end else begin
      case (b)
        8'h2B:   k = K_PLUS;    // +
        8'h2D:   k = K_MINUS;   // -
        8'h2F:   k = K_SLASH;   // /
        8'h2A:   k = K_STAR;    // *
        8'h3D:   k = K_EQUAL;   // =
        8'h28:   k = K_LPAREN;  // (
        8'h29:   k = K_RPAREN;  // )
        8'h3B:   k = K_SEMI;    // ;
        8'h2C:   k = K_COMMA;   // ,
        8'h3A:   k = K_COLON;   // :
        8'h5B:   k = K_LBRACK;  // [
        8'h5D:   k = K_RBRACK;  // ]
        8'h27:   k = K_QUOTE;   // '
        8'h40:   k = K_AT;      // @
        8'h23:   k = K_HASH;    // #
        8'h3F:   k = K_QMARK;   // ?
        8'h7C:   k = K_PIPE;    // |
        8'h24:   k = K_DOLLAR;  // $
        8'h5E:   k = K_CARET;   // ^
        8'h20, 8'h09, 8'h0A: k = K_SKIP;
        default: k = K_ERROR;
      endcase
    end
    return k;
  endfunction

endpackage

>>> hw/rtl/mml_core.sv
// Lexer state registers and the per-byte longest-match decision.
module mml_core #(
  parameter int unsigned POSITION_BITS = mml_pkg::POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [7:0]           text_byte,
  input  logic                 is_last,
  output mml_pkg::bundle_t     bundle,
  output mml_pkg::core_stat_t  stat
);
  import mml_pkg::*;

  localparam int unsigned P = POSITION_BITS;
  localparam logic [P-1:0] POS_MAX = '1;
  localparam logic [P-1:0] POS_ONE = P'(1);

  logic [4:0]   pkind_r, pkind_nxt;
  logic [P-1:0] pstart_r, pstart_nxt;
  logic [P-1:0] plen_r, plen_nxt;
  logic [P-1:0] pline_r, pline_nxt;
  logic [P-1:0] pcol_r, pcol_nxt;
  logic [P-1:0] offs_r, offs_nxt;
  logic [P-1:0] line_r, line_nxt;
  logic [P-1:0] lstart_r, lstart_nxt;
  logic         failed_r, failed_nxt;

  logic         clr;
  logic         err_hit;
  logic         ext;
  logic [4:0]   k;
  logic [P-1:0] colnow;
  logic [1:0]   n;

  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic logic [15:0] to_out(input logic [P-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic res_t mk(input logic [4:0] kind, input logic [P-1:0] start,
                              input logic [P-1:0] len, input logic [P-1:0] line,
                              input logic [P-1:0] col, input logic last);
    res_t r;
    r.kind  = kind;
    r.start = to_out(start);
    r.len   = to_out(len);
    r.line  = to_out(line);
    r.col   = to_out(col);
    r.last  = last;
    return r;
  endfunction

  always_comb begin
    pkind_nxt  = pkind_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    pline_nxt  = pline_r;
    pcol_nxt   = pcol_r;
    offs_nxt   = offs_r;
    line_nxt   = line_r;
    lstart_nxt = lstart_r;
    failed_nxt = failed_r;
    clr        = 1'b0;
    err_hit    = 1'b0;
    n          = 2'd0;
    bundle     = '0;
    k          = start_kind(text_byte);
    colnow     = sat_inc(offs_r - lstart_r);
    ext = ((pkind_r == K_INT) && is_digit(text_byte)) ||
          ((pkind_r == K_IDENT) && (is_alpha(text_byte) || is_digit(text_byte))) ||
          ((pkind_r == K_COLON) && (text_byte == CH_COLON)) ||
          ((pkind_r == K_PIPE) && (text_byte == CH_QUOTE));

    if (failed_r) begin
      // drop everything until the last byte, then start over
      clr = is_last;
    end else begin
      if (ext) begin
        plen_nxt = sat_inc(plen_r);
        if (pkind_r == K_COLON) begin
          pkind_nxt = K_DCOLON;
        end else if (pkind_r == K_PIPE) begin
          pkind_nxt = K_PIPEQ;
        end
      end else begin
        if (pkind_r != K_NONE) begin
          bundle.slot[n] = mk(pkind_r, pstart_r, plen_r, pline_r, pcol_r, 1'b0);
          n = n + 2'd1;
        end
        pkind_nxt = K_NONE;
        if (k == K_ERROR) begin
          bundle.slot[n] = mk(K_ERROR, offs_r, POS_ONE, line_r, colnow, 1'b1);
          n = n + 2'd1;
          err_hit = 1'b1;
          if (is_last) begin
            clr = 1'b1;
          end else begin
            failed_nxt = 1'b1;
          end
        end else if (k == K_SKIP) begin
          if (text_byte == CH_NEWLINE) begin
            line_nxt   = sat_inc(line_r);
            lstart_nxt = sat_inc(offs_r);
          end
        end else begin
          pkind_nxt  = k;
          pstart_nxt = offs_r;
          plen_nxt   = POS_ONE;
          pline_nxt  = line_r;
          pcol_nxt   = colnow;
        end
      end

      if (!err_hit) begin
        offs_nxt = sat_inc(offs_r);
        if (is_last) begin
          if (pkind_nxt != K_NONE) begin
            bundle.slot[n] = mk(pkind_nxt, pstart_nxt, plen_nxt, pline_nxt, pcol_nxt,
                                1'b0);
            n = n + 2'd1;
          end
          bundle.slot[n] = mk(K_END, offs_nxt, '0, line_nxt, offs_nxt - lstart_nxt,
                              1'b1);
          n = n + 2'd1;
          clr = 1'b1;
        end
      end
    end
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && clr)) begin
      pkind_r  <= K_NONE;
      pstart_r <= '0;
      plen_r   <= '0;
      pline_r  <= POS_ONE;
      pcol_r   <= POS_ONE;
      offs_r   <= '0;
      line_r   <= POS_ONE;
      lstart_r <= '0;
      failed_r <= 1'b0;
    end else if (adv) begin
      pkind_r  <= pkind_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      pline_r  <= pline_nxt;
      pcol_r   <= pcol_nxt;
      offs_r   <= offs_nxt;
      line_r   <= line_nxt;
      lstart_r <= lstart_nxt;
      failed_r <= failed_nxt;
    end
  end

  assign stat.failed     = failed_r;
  assign stat.pend_valid = (pkind_r != K_NONE);

endmodule

>>> hw/rtl/mml_outq.sv
// Result buffer: holds the results of one word and hands them out in order.
module mml_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  mml_pkg::bundle_t    bundle,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output mml_pkg::res_t       head
);
  import mml_pkg::*;

  res_t [NUM_SLOTS-1:0] slot_r;
  logic [1:0]           rem_r;
  logic                 pop;

  assign out_valid = (rem_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign free      = (rem_r == 2'd0) || ((rem_r == 2'd1) && pop);
  assign head      = slot_r[0];

  // payload: load a fresh set or advance by one
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= bundle.slot;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (load) begin
      rem_r <= bundle.cnt;
    end else if (pop) begin
      rem_r <= rem_r - 2'd1;
    end
  end

endmodule

>>> hw/rtl/maximal_munch_token_lexer.sv
// Top level of the maximal-munch token lexer: input register, lexer core, result buffer.
//
// The lexer takes one byte of text per word and splits the text into tokens by
// longest match: digit runs, identifiers, single-character operators and the
// two-byte tokens "::" and "|'". Blanks and newlines produce no word; each kept
// token leaves with kind, start offset, length, line and column once the next byte
// shows it cannot grow. A byte that starts no token flushes the pending token and
// produces an error word with last_result set; later bytes are dropped up to the
// one marked is_last, which returns the lexer to its reset state. The last byte
// otherwise flushes the pending token and adds an end marker. Positions saturate
// at 2^POSITION_BITS-1 and leave as their low 16 bits. Timing: an input word is
// captured in the input register and decided there by the combinational core, and
// its results are loaded into the result buffer when the held byte advances; the
// first result is shown from that buffer. The lexer takes one byte every cycle as
// long as results drain as fast as they come; a byte produces at most three results
// (on the last byte). The held byte advances into the three-entry result buffer only
// when that buffer is empty or its final word is taken in the same cycle, so a byte
// with several results stalls the input until its final result is being taken,
// and any stall on the result port stalls the input as well.
module maximal_munch_token_lexer #(
  parameter int unsigned POSITION_BITS = mml_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_token_length,
  output logic [15:0] out_line_number,
  output logic [15:0] out_column_number,
  output logic        out_last_result
);
  import mml_pkg::*;

  // input register
  logic       st_v_r;
  logic [7:0] st_byte_r;
  logic       st_last_r;

  logic       q_free;
  logic       adv;
  bundle_t    bundle;
  core_stat_t stat;
  res_t       head;

  // advance the held byte only when the buffer can take all its results
  assign adv      = st_v_r && q_free;
  assign in_stall = st_v_r && !q_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else if (!in_stall) begin
      st_v_r <= in_valid;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      st_byte_r <= in_text_byte;
      st_last_r <= in_is_last;
    end
  end

  mml_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .text_byte (st_byte_r),
    .is_last   (st_last_r),
    .bundle    (bundle),
    .stat      (stat)
  );

  mml_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .bundle    (bundle),
    .free      (q_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_token_kind    = head.kind;
  assign out_start_offset  = head.start;
  assign out_line_number   = head.line;
  assign out_token_length  = head.len;
  assign out_column_number = head.col;
  assign out_last_result   = head.last;

  // a byte taken while in the failed state yields nothing
  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stat.failed) |=> !out_valid)
    else $error("result produced while dropping bytes after an error");

  // an end marker has zero length and closes the text
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == K_END)) |-> (out_token_length == 16'd0) &&
                                                  out_last_result)
    else $error("malformed end marker");

  // an error result covers one byte and closes the text
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == K_ERROR)) |-> (out_token_length == 16'd1) &&
                                                    out_last_result)
    else $error("malformed error result");

  // a pending token never survives the last byte
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && st_last_r) |=> !stat.pend_valid && !stat.failed)
    else $error("lexer state not cleared after last byte");

endmodule
